// File: hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes and types of the first-fit heap allocator: operation modes,
// datapath commands and the status returned to the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int MODE_W  = 2;
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = 15;
  localparam int WORDS_W = 13;

  localparam logic [MODE_W-1:0] MODE_INIT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESIZE  = 2'd3;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_INIT,
    CMD_RD_CUR,
    CMD_WALK_NEXT,
    CMD_TAKE_C,
    CMD_RD_CNEXT,
    CMD_RD_CPREV,
    CMD_RD_FIX,
    CMD_WR_FIX,
    CMD_MERGE_N,
    CMD_MERGE_P,
    CMD_SPLIT_WS,
    CMD_WR_C_A1,
    CMD_WR_C_A0,
    CMD_FAIL,
    CMD_SAVE_OLD,
    CMD_LOAD_OLD
  } cmd_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              addr_zero;
    logic              addr_ok;
    logic              rd_alloc;
    logic              rd_hasn;
    logic              rd_fit;
    logic              rd_nfit;
    logic              cur_eq_tgt;
    logic              next_gt_tgt;
    logic              c_hasn;
    logic              c_hasp;
    logic              split_ok;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with neighbor coalescing over an on-chip header
// memory, one operation per command.
// ----------------------------------------------------------------------------
// An operation starts when start is high while busy is low; busy stays high
// until the result, which is shown for the single cycle in which done_o is
// high and must be taken then. An address that fails the alignment or range
// check is answered without a list walk. Allocate walks the chunk list
// first-fit, reading each chunk header in turn; release and resize first
// walk the list up to the named chunk and then read and write the neighbor
// headers. A resize that moves the block adds a full first-fit walk for the
// new block and the release of the old one. The header memory takes one
// header read or write per cycle, and after each result the block returns
// to idle, where the next item is taken.
`default_nettype none

module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES      = 32768,
  parameter int HEADER_BYTES    = 24,
  parameter int MIN_SPLIT_BYTES = 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start,
  output logic                            busy,
  input  wire  [ffha_pkg::MODE_W-1:0]     mode_i,
  input  wire  [ffha_pkg::SIZE_W-1:0]     size_i,
  input  wire  [ffha_pkg::ADDR_W-1:0]     address_i,
  output logic                            done_o,
  output logic [ffha_pkg::ADDR_W-1:0]     address_res_o,
  output logic                            status_o,
  output logic                            copy_needed_o,
  output logic [ffha_pkg::WORDS_W-1:0]    copy_words_o
);

  ffha_pkg::cmd_e       cmd;
  ffha_pkg::dp_status_t sts;

  ffha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  ffha_datapath #(
    .HEAP_BYTES      (HEAP_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (mode_i),
    .size_i        (size_i),
    .address_i     (address_i),
    .sts_o         (sts),
    .address_res_o (address_res_o),
    .status_o      (status_o),
    .copy_needed_o (copy_needed_o),
    .copy_words_o  (copy_words_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ffha_datapath.sv
// ----------------------------------------------------------------------------
// ffha_datapath
// Header memory, working header registers and the size and address
// arithmetic of the allocator. Acts on one command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_datapath #(
  parameter int HEAP_BYTES      = 32768,
  parameter int HEADER_BYTES    = 24,
  parameter int MIN_SPLIT_BYTES = 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  ffha_pkg::cmd_e                  cmd_i,
  input  wire  [ffha_pkg::MODE_W-1:0]     mode_i,
  input  wire  [ffha_pkg::SIZE_W-1:0]     size_i,
  input  wire  [ffha_pkg::ADDR_W-1:0]     address_i,
  output ffha_pkg::dp_status_t            sts_o,
  output logic [ffha_pkg::ADDR_W-1:0]     address_res_o,
  output logic                            status_o,
  output logic                            copy_needed_o,
  output logic [ffha_pkg::WORDS_W-1:0]    copy_words_o
);

  localparam int SLOTS = HEAP_BYTES / 8;
  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = $clog2(HEAP_BYTES);
  localparam int HDR   = ((HEADER_BYTES + 7) / 8) * 8;
  localparam int XW    = ((LW > ffha_pkg::SIZE_W) ? LW : ffha_pkg::SIZE_W) + 2;

  typedef struct packed {
    logic [SW-1:0] nxt;
    logic [SW-1:0] prv;
    logic [LW-1:0] len;
    logic          hasn;
    logic          hasp;
    logic          alloc;
  } hdr_t;

  hdr_t mem [SLOTS];

  logic [ffha_pkg::MODE_W-1:0]  mode_q, mode_d;
  logic [ffha_pkg::SIZE_W-1:0]  size_q, size_d;
  logic [ffha_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [SW-1:0]                cur_q, cur_d;
  logic [SW-1:0]                cs_q, cs_d;
  logic [SW-1:0]                old_q, old_d;
  logic [SW-1:0]                fix_q, fix_d;
  logic [SW-1:0]                fixv_q, fixv_d;
  hdr_t                         c_q, c_d;
  logic [ffha_pkg::ADDR_W-1:0]  res_q, res_d;
  logic                         stat_q, stat_d;
  logic                         copy_q, copy_d;
  logic [ffha_pkg::WORDS_W-1:0] words_q, words_d;
  hdr_t                         rd_q;
  logic [SW-1:0]                rd_slot_q;
  logic                         init_done_q;

  logic          we, re;
  logic [SW-1:0] wa, ra;
  hdr_t          wd, rdata;

  logic [XW-1:0] size_x, c_len_x, rd_len_x, round_x, s_x, addr_x, off_x;
  logic [XW-1:0] merge_n_x, rest_x, dat_x, min_x, words_x;
  logic [SW-1:0] tgt, s_slot;
  logic          addr_ok;

  // slot 0 reads as an empty header until it is first written
  assign rdata = (!init_done_q && rd_slot_q == '0) ? '0 : rd_q;

  assign size_x    = XW'(size_q);
  assign c_len_x   = XW'(c_q.len);
  assign rd_len_x  = XW'(rdata.len);
  assign round_x   = (size_x + XW'(7)) & ~XW'(7);
  assign s_x       = XW'(cs_q) + XW'(HDR / 8) + (round_x >> 3);
  assign s_slot    = s_x[SW-1:0];
  assign merge_n_x = c_len_x + rd_len_x + XW'(HDR);
  assign rest_x    = c_len_x - round_x - XW'(HDR);
  assign dat_x     = (XW'(cs_q) << 3) + XW'(HDR);
  assign min_x     = (size_x < c_len_x) ? size_x : c_len_x;
  assign words_x   = (min_x + XW'(7)) >> 3;

  assign addr_x  = XW'(addr_q);
  assign off_x   = addr_x - XW'(HDR);
  assign tgt     = SW'(off_x >> 3);
  assign addr_ok = (addr_x >= XW'(HDR)) && (off_x[2:0] == 3'd0)
                   && ((off_x >> 3) < XW'(SLOTS));

  always_comb begin
    sts_o.mode        = mode_q;
    sts_o.addr_zero   = (addr_q == '0);
    sts_o.addr_ok     = addr_ok;
    sts_o.rd_alloc    = rdata.alloc;
    sts_o.rd_hasn     = rdata.hasn;
    sts_o.rd_fit      = (size_x <= rd_len_x);
    sts_o.rd_nfit     = (size_x <= merge_n_x);
    sts_o.cur_eq_tgt  = (cur_q == tgt);
    sts_o.next_gt_tgt = (rdata.nxt > tgt);
    sts_o.c_hasn      = c_q.hasn;
    sts_o.c_hasp      = c_q.hasp;
    sts_o.split_ok    = (c_len_x >= round_x)
                        && ((c_len_x - round_x) >= XW'(MIN_SPLIT_BYTES + HDR))
                        && (s_x < XW'(SLOTS));
  end

  always_comb begin
    mode_d  = mode_q;
    size_d  = size_q;
    addr_d  = addr_q;
    cur_d   = cur_q;
    cs_d    = cs_q;
    old_d   = old_q;
    fix_d   = fix_q;
    fixv_d  = fixv_q;
    c_d     = c_q;
    res_d   = res_q;
    stat_d  = stat_q;
    copy_d  = copy_q;
    words_d = words_q;
    we      = 1'b0;
    wa      = '0;
    wd      = '0;
    re      = 1'b0;
    ra      = '0;
    case (cmd_i)
      ffha_pkg::CMD_LOAD: begin
        mode_d  = mode_i;
        size_d  = size_i;
        addr_d  = address_i;
        cur_d   = '0;
        res_d   = '0;
        stat_d  = 1'b0;
        copy_d  = 1'b0;
        words_d = '0;
      end
      ffha_pkg::CMD_INIT: begin
        we     = 1'b1;
        wd.len = LW'(HEAP_BYTES - HDR);
      end
      ffha_pkg::CMD_RD_CUR: begin
        re = 1'b1;
        ra = cur_q;
      end
      ffha_pkg::CMD_WALK_NEXT: cur_d = rdata.nxt;
      ffha_pkg::CMD_TAKE_C: begin
        c_d  = rdata;
        cs_d = cur_q;
      end
      ffha_pkg::CMD_RD_CNEXT: begin
        re = 1'b1;
        ra = c_q.nxt;
      end
      ffha_pkg::CMD_RD_CPREV: begin
        re = 1'b1;
        ra = c_q.prv;
      end
      ffha_pkg::CMD_RD_FIX: begin
        re = 1'b1;
        ra = fix_q;
      end
      ffha_pkg::CMD_WR_FIX: begin
        we      = 1'b1;
        wa      = fix_q;
        wd      = rdata;
        wd.prv  = fixv_q;
        wd.hasp = 1'b1;
      end
      ffha_pkg::CMD_MERGE_N: begin
        c_d.nxt  = rdata.nxt;
        c_d.hasn = rdata.hasn;
        c_d.len  = merge_n_x[LW-1:0];
        fix_d    = rdata.nxt;
        fixv_d   = cs_q;
      end
      ffha_pkg::CMD_MERGE_P: begin
        we       = 1'b1;
        wa       = c_q.prv;
        wd       = rdata;
        wd.nxt   = c_q.nxt;
        wd.hasn  = c_q.hasn;
        wd.len   = merge_n_x[LW-1:0];
        fix_d    = c_q.nxt;
        fixv_d   = c_q.prv;
      end
      ffha_pkg::CMD_SPLIT_WS: begin
        we       = 1'b1;
        wa       = s_slot;
        wd.nxt   = c_q.nxt;
        wd.hasn  = c_q.hasn;
        wd.prv   = cs_q;
        wd.hasp  = 1'b1;
        wd.alloc = 1'b0;
        wd.len   = rest_x[LW-1:0];
        fix_d    = c_q.nxt;
        fixv_d   = s_slot;
        c_d.nxt  = s_slot;
        c_d.hasn = 1'b1;
        c_d.len  = round_x[LW-1:0];
      end
      ffha_pkg::CMD_WR_C_A1: begin
        we       = 1'b1;
        wa       = cs_q;
        wd       = c_q;
        wd.alloc = 1'b1;
        res_d    = dat_x[ffha_pkg::ADDR_W-1:0];
      end
      ffha_pkg::CMD_WR_C_A0: begin
        we       = 1'b1;
        wa       = cs_q;
        wd       = c_q;
        wd.alloc = 1'b0;
      end
      ffha_pkg::CMD_FAIL: begin
        res_d   = '0;
        stat_d  = 1'b1;
        copy_d  = 1'b0;
        words_d = '0;
      end
      ffha_pkg::CMD_SAVE_OLD: begin
        old_d   = cs_q;
        words_d = words_x[ffha_pkg::WORDS_W-1:0];
        copy_d  = 1'b1;
        cur_d   = '0;
      end
      ffha_pkg::CMD_LOAD_OLD: cur_d = old_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (re) rd_slot_q <= ra;
    mode_q  <= mode_d;
    size_q  <= size_d;
    addr_q  <= addr_d;
    cur_q   <= cur_d;
    cs_q    <= cs_d;
    old_q   <= old_d;
    fix_q   <= fix_d;
    fixv_q  <= fixv_d;
    c_q     <= c_d;
    res_q   <= res_d;
    stat_q  <= stat_d;
    copy_q  <= copy_d;
    words_q <= words_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_done_q <= 1'b0;
    end else if (we && wa == '0) begin
      init_done_q <= 1'b1;
    end
  end

  assign address_res_o = res_q;
  assign status_o      = stat_q;
  assign copy_needed_o = copy_q;
  assign copy_words_o  = words_q;

endmodule

`default_nettype wire

// File: hw/rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer of the allocator: walks the chunk list and orders the header
// reads and writes of allocate, release and resize.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  input  ffha_pkg::dp_status_t sts_i,
  output ffha_pkg::cmd_e       cmd_o,
  output logic                 busy,
  output logic                 done_o
);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_DISP  = 6'd1;
  localparam logic [5:0] S_INIT  = 6'd2;
  localparam logic [5:0] S_VRD   = 6'd3;
  localparam logic [5:0] S_VEV   = 6'd4;
  localparam logic [5:0] S_ARD   = 6'd5;
  localparam logic [5:0] S_AEV   = 6'd6;
  localparam logic [5:0] S_SPCHK = 6'd7;
  localparam logic [5:0] S_SPWS  = 6'd8;
  localparam logic [5:0] S_SPFR  = 6'd9;
  localparam logic [5:0] S_SPFW  = 6'd10;
  localparam logic [5:0] S_WCA   = 6'd11;
  localparam logic [5:0] S_LDOLD = 6'd12;
  localparam logic [5:0] S_ORD   = 6'd13;
  localparam logic [5:0] S_OEV   = 6'd14;
  localparam logic [5:0] S_R0    = 6'd15;
  localparam logic [5:0] S_RNRD  = 6'd16;
  localparam logic [5:0] S_RNEV  = 6'd17;
  localparam logic [5:0] S_RNFR  = 6'd18;
  localparam logic [5:0] S_RNFW  = 6'd19;
  localparam logic [5:0] S_RP0   = 6'd20;
  localparam logic [5:0] S_RPRD  = 6'd21;
  localparam logic [5:0] S_RPEV  = 6'd22;
  localparam logic [5:0] S_RPFR  = 6'd23;
  localparam logic [5:0] S_RPFW  = 6'd24;
  localparam logic [5:0] S_WC0   = 6'd25;
  localparam logic [5:0] S_Z0    = 6'd26;
  localparam logic [5:0] S_ZNRD  = 6'd27;
  localparam logic [5:0] S_ZNEV  = 6'd28;
  localparam logic [5:0] S_ZNFR  = 6'd29;
  localparam logic [5:0] S_ZNFW  = 6'd30;
  localparam logic [5:0] S_MV    = 6'd31;
  localparam logic [5:0] S_DONE  = 6'd32;

  logic [5:0] state_q, state_d;
  logic       move_q, move_d;

  always_comb begin
    state_d = state_q;
    move_d  = move_q;
    cmd_o   = ffha_pkg::CMD_NOP;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = ffha_pkg::CMD_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.mode)
          ffha_pkg::MODE_INIT:    state_d = S_INIT;
          ffha_pkg::MODE_ALLOC:   state_d = S_ARD;
          ffha_pkg::MODE_RELEASE: state_d = sts_i.addr_ok ? S_VRD : S_DONE;
          default: begin
            if (sts_i.addr_zero) state_d = S_ARD;
            else if (sts_i.addr_ok) state_d = S_VRD;
            else state_d = S_DONE;
          end
        endcase
      end
      S_INIT: begin
        cmd_o   = ffha_pkg::CMD_INIT;
        state_d = S_DONE;
      end
      // find the addressed chunk by walking the list in address order
      S_VRD: begin
        cmd_o   = ffha_pkg::CMD_RD_CUR;
        state_d = S_VEV;
      end
      S_VEV: begin
        if (sts_i.cur_eq_tgt) begin
          if (sts_i.rd_alloc) begin
            cmd_o   = ffha_pkg::CMD_TAKE_C;
            state_d = (sts_i.mode == ffha_pkg::MODE_RELEASE) ? S_R0 : S_Z0;
          end else begin
            state_d = S_DONE;
          end
        end else if (!sts_i.rd_hasn || sts_i.next_gt_tgt) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = ffha_pkg::CMD_WALK_NEXT;
          state_d = S_VRD;
        end
      end
      // first-fit walk
      S_ARD: begin
        cmd_o   = ffha_pkg::CMD_RD_CUR;
        state_d = S_AEV;
      end
      S_AEV: begin
        if (!sts_i.rd_alloc && sts_i.rd_fit) begin
          cmd_o   = ffha_pkg::CMD_TAKE_C;
          state_d = S_SPCHK;
        end else if (!sts_i.rd_hasn) begin
          cmd_o   = ffha_pkg::CMD_FAIL;
          move_d  = 1'b0;
          state_d = S_DONE;
        end else begin
          cmd_o   = ffha_pkg::CMD_WALK_NEXT;
          state_d = S_ARD;
        end
      end
      S_SPCHK: state_d = sts_i.split_ok ? S_SPWS : S_WCA;
      S_SPWS: begin
        cmd_o   = ffha_pkg::CMD_SPLIT_WS;
        state_d = sts_i.c_hasn ? S_SPFR : S_WCA;
      end
      S_SPFR: begin
        cmd_o   = ffha_pkg::CMD_RD_FIX;
        state_d = S_SPFW;
      end
      S_SPFW: begin
        cmd_o   = ffha_pkg::CMD_WR_FIX;
        state_d = S_WCA;
      end
      S_WCA: begin
        cmd_o   = ffha_pkg::CMD_WR_C_A1;
        state_d = move_q ? S_LDOLD : S_DONE;
      end
      // moved resize: reread the old chunk, then release it
      S_LDOLD: begin
        cmd_o   = ffha_pkg::CMD_LOAD_OLD;
        move_d  = 1'b0;
        state_d = S_ORD;
      end
      S_ORD: begin
        cmd_o   = ffha_pkg::CMD_RD_CUR;
        state_d = S_OEV;
      end
      S_OEV: begin
        cmd_o   = ffha_pkg::CMD_TAKE_C;
        state_d = S_R0;
      end
      S_R0: state_d = sts_i.c_hasn ? S_RNRD : S_RP0;
      S_RNRD: begin
        cmd_o   = ffha_pkg::CMD_RD_CNEXT;
        state_d = S_RNEV;
      end
      S_RNEV: begin
        if (!sts_i.rd_alloc) begin
          cmd_o   = ffha_pkg::CMD_MERGE_N;
          state_d = sts_i.rd_hasn ? S_RNFR : S_RP0;
        end else begin
          state_d = S_RP0;
        end
      end
      S_RNFR: begin
        cmd_o   = ffha_pkg::CMD_RD_FIX;
        state_d = S_RNFW;
      end
      S_RNFW: begin
        cmd_o   = ffha_pkg::CMD_WR_FIX;
        state_d = S_RP0;
      end
      S_RP0: state_d = sts_i.c_hasp ? S_RPRD : S_WC0;
      S_RPRD: begin
        cmd_o   = ffha_pkg::CMD_RD_CPREV;
        state_d = S_RPEV;
      end
      S_RPEV: begin
        if (!sts_i.rd_alloc) begin
          cmd_o   = ffha_pkg::CMD_MERGE_P;
          state_d = sts_i.c_hasn ? S_RPFR : S_DONE;
        end else begin
          state_d = S_WC0;
        end
      end
      S_RPFR: begin
        cmd_o   = ffha_pkg::CMD_RD_FIX;
        state_d = S_RPFW;
      end
      S_RPFW: begin
        cmd_o   = ffha_pkg::CMD_WR_FIX;
        state_d = S_DONE;
      end
      S_WC0: begin
        cmd_o   = ffha_pkg::CMD_WR_C_A0;
        state_d = S_DONE;
      end
      // resize: try to grow into a free next chunk
      S_Z0: state_d = sts_i.c_hasn ? S_ZNRD : S_MV;
      S_ZNRD: begin
        cmd_o   = ffha_pkg::CMD_RD_CNEXT;
        state_d = S_ZNEV;
      end
      S_ZNEV: begin
        if (!sts_i.rd_alloc && sts_i.rd_nfit) begin
          cmd_o   = ffha_pkg::CMD_MERGE_N;
          state_d = sts_i.rd_hasn ? S_ZNFR : S_SPCHK;
        end else begin
          state_d = S_MV;
        end
      end
      S_ZNFR: begin
        cmd_o   = ffha_pkg::CMD_RD_FIX;
        state_d = S_ZNFW;
      end
      S_ZNFW: begin
        cmd_o   = ffha_pkg::CMD_WR_FIX;
        state_d = S_SPCHK;
      end
      S_MV: begin
        cmd_o   = ffha_pkg::CMD_SAVE_OLD;
        move_d  = 1'b1;
        state_d = S_ARD;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      move_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      move_q  <= move_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire

// File: sim/first_fit_heap_allocator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core_test
// Self-checking bench for the first-fit heap allocator. A behavioral copy of
// the chunk list predicts every answer; directed cases cover the corners,
// then long random runs of init/allocate/release/resize, mostly with random gaps, follow.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_core_test;

  localparam int HEAP  = 32768;
  localparam int HDRB  = 24;
  localparam int MINSP = 8;
  localparam int NSLOT = HEAP / 8;

  typedef struct packed {
    logic [ffha_pkg::ADDR_W-1:0]  addr;
    logic                         oom;
    logic                         copy;
    logic [ffha_pkg::WORDS_W-1:0] words;
  } answer_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic [ffha_pkg::MODE_W-1:0]   mode_i = ffha_pkg::MODE_INIT;
  logic [ffha_pkg::SIZE_W-1:0]   size_i = '0;
  logic [ffha_pkg::ADDR_W-1:0]   address_i = '0;
  wire                           busy, done_o, status_o, copy_needed_o;
  wire [ffha_pkg::ADDR_W-1:0]    address_res_o;
  wire [ffha_pkg::WORDS_W-1:0]   copy_words_o;

  first_fit_heap_allocator_core dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .size_i, .address_i,
    .done_o, .address_res_o, .status_o, .copy_needed_o, .copy_words_o
  );

  always #6 clk_i = ~clk_i;

  // chunk list mirror
  int unsigned ch_next[NSLOT], ch_prev[NSLOT], ch_len[NSLOT];
  bit          ch_hasn[NSLOT], ch_hasp[NSLOT], ch_alloc[NSLOT], ch_live[NSLOT];

  answer_t     pending_answers[$];
  int unsigned owned_blocks[$];
  int          errors = 0;
  bit          no_gaps = 0;

  function automatic void heap_clear();
    for (int i = 0; i < NSLOT; i++) begin
      ch_next[i] = 0; ch_prev[i] = 0; ch_len[i] = 0;
      ch_hasn[i] = 0; ch_hasp[i] = 0; ch_alloc[i] = 0; ch_live[i] = 0;
    end
    ch_live[0] = 1;
  endfunction

  function automatic void heap_split(int unsigned c, int unsigned sz);
    int unsigned r, l, s;
    r = (sz + 7) & ~32'd7;
    l = ch_len[c];
    if (l >= r && l - r >= MINSP + HDRB) begin
      s = (c * 8 + HDRB + r) / 8;
      if (s >= NSLOT) return;
      ch_next[s] = ch_next[c];
      ch_hasn[s] = ch_hasn[c];
      if (ch_hasn[c]) begin
        ch_prev[ch_next[c]] = s;
        ch_hasp[ch_next[c]] = 1;
      end
      ch_next[c] = s; ch_hasn[c] = 1;
      ch_prev[s] = c; ch_hasp[s] = 1;
      ch_alloc[s] = 0; ch_live[s] = 1;
      ch_len[s] = l - r - HDRB;
      ch_len[c] = r;
    end
  endfunction

  function automatic bit heap_first_fit(int unsigned sz, output int unsigned slot);
    int unsigned c;
    c = 0;
    slot = 0;
    for (int n = 0; n < NSLOT; n++) begin
      if (!ch_alloc[c] && sz <= ch_len[c]) begin
        heap_split(c, sz);
        ch_alloc[c] = 1;
        slot = c;
        return 1;
      end
      if (!ch_hasn[c]) return 0;
      c = ch_next[c];
    end
    return 0;
  endfunction

  function automatic void heap_absorb_next(int unsigned c);
    int unsigned nx;
    nx = ch_next[c];
    ch_next[c] = ch_next[nx];
    ch_hasn[c] = ch_hasn[nx];
    if (ch_hasn[c]) begin
      ch_prev[ch_next[c]] = c;
      ch_hasp[ch_next[c]] = 1;
    end
    ch_len[c] += ch_len[nx] + HDRB;
    ch_live[nx] = 0;
  endfunction

  function automatic void heap_release(int unsigned c);
    int unsigned p;
    ch_alloc[c] = 0;
    if (ch_hasn[c] && !ch_alloc[ch_next[c]]) heap_absorb_next(c);
    if (ch_hasp[c] && !ch_alloc[ch_prev[c]]) begin
      p = ch_prev[c];
      ch_next[p] = ch_next[c];
      ch_hasn[p] = ch_hasn[c];
      if (ch_hasn[c]) ch_prev[ch_next[c]] = p;
      ch_len[p] += ch_len[c] + HDRB;
      ch_live[c] = 0;
    end
  endfunction

  function automatic bit heap_lookup(int unsigned a, output int unsigned slot);
    int unsigned s;
    slot = 0;
    if (a < HDRB || ((a - HDRB) & 7) != 0) return 0;
    s = (a - HDRB) / 8;
    if (s >= NSLOT || !ch_live[s] || !ch_alloc[s]) return 0;
    slot = s;
    return 1;
  endfunction

  function automatic void forget_block(int unsigned a);
    foreach (owned_blocks[i])
      if (owned_blocks[i] == a) begin
        owned_blocks.delete(i);
        return;
      end
  endfunction

  // Apply one command to the mirror and return the answer it must produce.
  function automatic answer_t heap_predict(logic [ffha_pkg::MODE_W-1:0] m,
                                           int unsigned sz, int unsigned a);
    answer_t     ans;
    int unsigned c, n, len;
    ans = '0;
    case (m)
      ffha_pkg::MODE_INIT: begin
        heap_clear();
        ch_len[0] = HEAP - HDRB;
        owned_blocks.delete();
      end
      ffha_pkg::MODE_ALLOC: begin
        if (heap_first_fit(sz, n)) ans.addr = 15'(n * 8 + HDRB);
        else ans.oom = 1'b1;
      end
      ffha_pkg::MODE_RELEASE: begin
        if (heap_lookup(a, c)) begin
          heap_release(c);
          forget_block(a);
        end
      end
      default: begin
        if (a == 0) begin
          if (heap_first_fit(sz, n)) ans.addr = 15'(n * 8 + HDRB);
          else ans.oom = 1'b1;
        end else if (heap_lookup(a, c)) begin
          n = ch_next[c];
          if (ch_hasn[c] && !ch_alloc[n] && sz <= ch_len[c] + ch_len[n] + HDRB) begin
            heap_absorb_next(c);
            heap_split(c, sz);
            ans.addr = 15'(c * 8 + HDRB);
          end else begin
            len = (sz < ch_len[c]) ? sz : ch_len[c];
            if (heap_first_fit(sz, n)) begin
              ans.addr  = 15'(n * 8 + HDRB);
              ans.copy  = 1'b1;
              ans.words = 13'((len + 7) / 8);
              heap_release(c);
              forget_block(a);
            end else begin
              ans.oom = 1'b1;
            end
          end
        end
      end
    endcase
    if ((m == ffha_pkg::MODE_ALLOC || m == ffha_pkg::MODE_RESIZE) && ans.addr != 0 &&
        !ans.copy && !(m == ffha_pkg::MODE_RESIZE && a != 0))
      owned_blocks.push_back(ans.addr);
    if (ans.copy) owned_blocks.push_back(ans.addr);
    return ans;
  endfunction

  // Called at a rising edge; returns at the edge that follows the item's gap.
  task automatic send_item(logic [ffha_pkg::MODE_W-1:0] m, logic [ffha_pkg::SIZE_W-1:0] sz,
                           logic [ffha_pkg::ADDR_W-1:0] a);
    int r, gap;
    start <= 1'b1; mode_i <= m; size_i <= sz; address_i <= a;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    pending_answers.push_back(heap_predict(m, sz, a));
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                : $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        $error("result with nothing pending: address_res %0d", address_res_o);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (address_res_o !== want.addr) begin
          $error("address_res: expected %0d, got %0d", want.addr, address_res_o);
          errors++;
        end
        if (status_o !== want.oom) begin
          $error("status: expected %0d, got %0d", want.oom, status_o);
          errors++;
        end
        if (copy_needed_o !== want.copy) begin
          $error("copy_needed: expected %0d, got %0d", want.copy, copy_needed_o);
          errors++;
        end
        if (copy_words_o !== want.words) begin
          $error("copy_words: expected %0d, got %0d", want.words, copy_words_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [ffha_pkg::ADDR_W-1:0] pick_block();
    if (owned_blocks.size() == 0) return '0;
    return 15'(owned_blocks[$urandom_range(0, owned_blocks.size() - 1)]);
  endfunction

  task automatic test_directed();
    logic [ffha_pkg::ADDR_W-1:0] a, b, c;
    send_item(ffha_pkg::MODE_INIT, 0, 0);
    send_item(ffha_pkg::MODE_ALLOC, 16'hFFFF, 0);            // out of memory
    send_item(ffha_pkg::MODE_ALLOC, 16'(HEAP - HDRB), 0);    // whole heap, no split
    send_item(ffha_pkg::MODE_ALLOC, 0, 0);                   // heap full
    send_item(ffha_pkg::MODE_RESIZE, 1, 15'(HDRB));          // cannot move
    send_item(ffha_pkg::MODE_RELEASE, 0, 15'(HDRB));
    send_item(ffha_pkg::MODE_RELEASE, 0, 15'(HDRB));         // already free
    send_item(ffha_pkg::MODE_RELEASE, 0, 0);                 // null
    send_item(ffha_pkg::MODE_RELEASE, 0, 15'h7FFF);          // unaligned
    send_item(ffha_pkg::MODE_ALLOC, 0, 0);
    send_item(ffha_pkg::MODE_ALLOC, 1, 0);
    send_item(ffha_pkg::MODE_ALLOC, 8, 0);
    a = 15'(HDRB); b = 15'(2 * HDRB); c = 15'(2 * HDRB + 8 + HDRB);
    send_item(ffha_pkg::MODE_RESIZE, 40, 0);                 // null resize allocates
    send_item(ffha_pkg::MODE_RESIZE, 4, 15'h7FF8);           // nonzero address that names no block
    send_item(ffha_pkg::MODE_RELEASE, 0, b);
    send_item(ffha_pkg::MODE_RESIZE, 24, a);                 // grow into freed neighbor
    send_item(ffha_pkg::MODE_RESIZE, 16'hFFFF, c);           // too big anywhere
    send_item(ffha_pkg::MODE_RESIZE, 200, c);                // moves, copy reported
    send_item(ffha_pkg::MODE_RELEASE, 0, a);                 // merge with the free next neighbor
    send_item(ffha_pkg::MODE_RESIZE, 16'hFFF8, pick_block());
    send_item(ffha_pkg::MODE_RELEASE, 0, pick_block());
    send_item(ffha_pkg::MODE_RELEASE, 0, pick_block());
  endtask

  task automatic test_random(int count);
    int                          r;
    logic [ffha_pkg::SIZE_W-1:0] sz;
    logic [ffha_pkg::ADDR_W-1:0] a;
    repeat (count) begin
      r = $urandom_range(0, 99);
      sz = 16'((r < 70) ? $urandom_range(0, 256) : (r < 90) ? $urandom_range(0, 4096)
         : (r < 95) ? $urandom_range(0, 32768) : $urandom);
      r = $urandom_range(0, 99);
      a = (r < 80) ? pick_block() : (r < 90) ? 15'($urandom) : '0;
      r = $urandom_range(0, 999);
      if (r < 8) send_item(ffha_pkg::MODE_INIT, 16'($urandom), 15'($urandom));
      else if (r < 400) send_item(ffha_pkg::MODE_ALLOC, sz, 15'($urandom));
      else if (r < 780) send_item(ffha_pkg::MODE_RELEASE, 16'($urandom), a);
      else send_item(ffha_pkg::MODE_RESIZE, sz, a);
    end
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    wait (pending_answers.size() == 0);
    @(posedge clk_i);
    test_random(50);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700);
    test_drain_pause();
    no_gaps = 1;
    test_random(300);
    no_gaps = 0;
    send_item(ffha_pkg::MODE_INIT, 0, 0);
    test_random(680);
    start <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("** first_fit_heap_allocator_core: PASSED **");
    end else begin
      $display("** first_fit_heap_allocator_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #1s;
    $display("** first_fit_heap_allocator_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
